// File: design/nmea_sentence_checker_top_assert.svh
// Assertion macros for the NMEA sentence checker.
// Used by nmea_sentence_checker_top; no other dependencies.
`ifndef NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NMEA_CHK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NMEA_CHK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/nmea_chk_pkg.sv
// Shared types, character codes and helper functions for the NMEA sentence checker.
// No dependencies; used by the channel interface users and the top level.
package nmea_chk_pkg;

   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int PREFIX_LEN = 6;

   // The first six characters of the two recognised sentence types, first character at the top.
   localparam logic [8*PREFIX_LEN-1:0] PREFIX_GGA = 48'h24_47_50_47_47_41;
   localparam logic [8*PREFIX_LEN-1:0] PREFIX_RMC = 48'h24_47_50_52_4D_43;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_GGA   = 2'd1,
      KIND_RMC   = 2'd2
   } line_kind_type;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_SCAN  = 3'd1,
      PH_SUM0  = 3'd2,
      PH_SUM1  = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       line_ok;
      logic [1:0] line_kind;
      logic [7:0] computed_sum;
   } rsp_payload_type;

   // Upper-case ASCII hex character for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'h0, nibble};
      if (nibble < 4'd10) begin
         return 8'h30 + wide;
      end else begin
         return 8'h41 + wide - 8'd10;
      end
   endfunction

endpackage

// File: design/nmea_chk_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
// The payload type comes from nmea_chk_pkg at the point of instantiation.
interface nmea_chk_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/nmea_sentence_checker_top.sv
// NMEA sentence checker: checks start character, checksum and sentence type per line.
// A line-ending byte passes the input register, then its result goes to the result register.
// Throughput: one byte per cycle; the output register lets the next byte in while a
// result waits, and only a line end meeting a full, unread output register stalls.
// Reset: synchronous, active high; clears the line state and both valid flags.
// Depends on nmea_chk_pkg, nmea_chk_stream_if and nmea_sentence_checker_top_assert.svh.
`include "nmea_sentence_checker_top_assert.svh"

module nmea_sentence_checker_top #(
   parameter int LINE_CAPACITY = 128,
   parameter int SCAN_LIMIT    = 75
) (
   input  logic              clock,
   input  logic              reset,
   nmea_chk_stream_if.sink   req_chan,
   nmea_chk_stream_if.source rsp_chan
);

   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;

   // Line state.
   logic [FILL_W-1:0]      fill_count_ff, fill_count_in;
   nmea_chk_pkg::phase_type phase_ff, phase_in;
   logic [7:0]             running_xor_ff, running_xor_in;
   logic [7:0]             sum_chars_ff [2];
   logic [7:0]             sum_chars_in [2];
   logic [7:0]             prefix_ff [nmea_chk_pkg::PREFIX_LEN];
   logic [7:0]             prefix_in [nmea_chk_pkg::PREFIX_LEN];
   logic                   scan_failed_ff, scan_failed_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   nmea_chk_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic line_end, out_free, s1_go, req_take, past_limit;
   logic sum_match;
   logic [8*nmea_chk_pkg::PREFIX_LEN-1:0] prefix_flat;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign line_end = (s1_byte_ff == nmea_chk_pkg::CH_LF) ||
                     (fill_count_ff >= FILL_W'(LINE_CAPACITY));
   // A byte that ends a line needs room in the output register; any other byte always moves.
   assign s1_go    = s1_valid_ff && (!line_end || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take = req_chan.valid && req_chan.ready;

   assign past_limit = {{(32 - FILL_W){1'b0}}, fill_count_ff} >= 32'(SCAN_LIMIT);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_comb begin
      for (int i = 0; i < nmea_chk_pkg::PREFIX_LEN; i++) begin
         prefix_flat[8*(nmea_chk_pkg::PREFIX_LEN-1-i) +: 8] = prefix_ff[i];
      end
   end

   assign sum_match =
      (sum_chars_ff[0] == nmea_chk_pkg::hex_digit(running_xor_ff[7:4])) &&
      (sum_chars_ff[1] == nmea_chk_pkg::hex_digit(running_xor_ff[3:0]));

   // Result of the line held in the state registers, loaded when a line end moves on.
   always_comb begin
      rsp_payload_in.line_ok      = (phase_ff == nmea_chk_pkg::PH_DONE) &&
                                    !scan_failed_ff && sum_match;
      rsp_payload_in.computed_sum = running_xor_ff;
      rsp_payload_in.line_kind    = nmea_chk_pkg::KIND_OTHER;
      if (rsp_payload_in.line_ok) begin
         if (prefix_flat == nmea_chk_pkg::PREFIX_GGA) begin
            rsp_payload_in.line_kind = nmea_chk_pkg::KIND_GGA;
         end else if (prefix_flat == nmea_chk_pkg::PREFIX_RMC) begin
            rsp_payload_in.line_kind = nmea_chk_pkg::KIND_RMC;
         end
      end
   end

   // Next line state.
   always_comb begin
      fill_count_in  = fill_count_ff;
      phase_in       = phase_ff;
      running_xor_in = running_xor_ff;
      sum_chars_in   = sum_chars_ff;
      prefix_in      = prefix_ff;
      scan_failed_in = scan_failed_ff;

      if (s1_go) begin
         if (line_end) begin
            fill_count_in  = '0;
            phase_in       = nmea_chk_pkg::PH_START;
            running_xor_in = '0;
            scan_failed_in = 1'b0;
            for (int i = 0; i < 2; i++) begin
               sum_chars_in[i] = '0;
            end
            for (int i = 0; i < nmea_chk_pkg::PREFIX_LEN; i++) begin
               prefix_in[i] = '0;
            end
         end else begin
            fill_count_in = fill_count_ff + FILL_W'(1);
            for (int i = 0; i < nmea_chk_pkg::PREFIX_LEN; i++) begin
               if ({{(32 - FILL_W){1'b0}}, fill_count_ff} == 32'(i)) begin
                  prefix_in[i] = s1_byte_ff;
               end
            end
            unique case (phase_ff)
               nmea_chk_pkg::PH_START: begin
                  if (s1_byte_ff == nmea_chk_pkg::CH_START) begin
                     phase_in = nmea_chk_pkg::PH_SCAN;
                  end else begin
                     phase_in       = nmea_chk_pkg::PH_DONE;
                     scan_failed_in = 1'b1;
                  end
               end
               nmea_chk_pkg::PH_SCAN: begin
                  if (past_limit || s1_byte_ff == nmea_chk_pkg::CH_NUL) begin
                     phase_in       = nmea_chk_pkg::PH_DONE;
                     scan_failed_in = 1'b1;
                  end else if (s1_byte_ff == nmea_chk_pkg::CH_STAR) begin
                     phase_in = nmea_chk_pkg::PH_SUM0;
                  end else begin
                     running_xor_in = running_xor_ff ^ s1_byte_ff;
                  end
               end
               nmea_chk_pkg::PH_SUM0: begin
                  sum_chars_in[0] = s1_byte_ff;
                  phase_in        = nmea_chk_pkg::PH_SUM1;
               end
               nmea_chk_pkg::PH_SUM1: begin
                  sum_chars_in[1] = s1_byte_ff;
                  phase_in        = nmea_chk_pkg::PH_DONE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_go && line_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fill_count_ff  <= '0;
         phase_ff       <= nmea_chk_pkg::PH_START;
         running_xor_ff <= '0;
         scan_failed_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            sum_chars_ff[i] <= '0;
         end
         for (int i = 0; i < nmea_chk_pkg::PREFIX_LEN; i++) begin
            prefix_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         fill_count_ff  <= fill_count_in;
         phase_ff       <= phase_in;
         running_xor_ff <= running_xor_in;
         scan_failed_ff <= scan_failed_in;
         sum_chars_ff   <= sum_chars_in;
         prefix_ff      <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.payload.rx_byte;
      end
      if (s1_go && line_end) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // A finished line must never overwrite a result that has not yet been transferred.
   `NMEA_CHK_ASSERT_NOW(a_no_result_overwrite, clock, reset,
      s1_go && line_end, out_free, "line result would overwrite a pending result")

   // After a line end the line state starts afresh.
   `NMEA_CHK_ASSERT_NEXT(a_clear_after_end, clock, reset,
      s1_go && line_end,
      fill_count_ff == '0 && phase_ff == nmea_chk_pkg::PH_START && running_xor_ff == '0,
      "line state not cleared after a line end")

   // A recognised sentence type is only ever reported for a valid line.
   `NMEA_CHK_ASSERT_NOW(a_kind_needs_ok, clock, reset,
      rsp_valid_ff && rsp_payload_ff.line_kind != nmea_chk_pkg::KIND_OTHER,
      rsp_payload_ff.line_ok, "sentence type reported for a failed line")

endmodule
